[rtl/core/kmt_pkg.sv]
// Shared types, constants and key layout for the key matrix tracker.
// Depends on nothing; kmt_if.sv and the top level use it.
package kmt_pkg;

  // Field widths
  localparam int TIME_W     = 32;
  localparam int MATRIX_W   = 28;
  localparam int DELAY_W    = 16;
  localparam int CODE_W     = 5;
  localparam int CELL_BIT_W = 6;   // bit index of an 8x8 layout
  localparam int POS_W      = 3;   // row or column of an 8x8 layout
  localparam int MODE_W     = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 2'd1;

  localparam logic [DELAY_W-1:0] DEBOUNCE_RST = 16'd10;
  localparam logic [DELAY_W-1:0] HOLD_RST     = 16'd500;

  // Events per scan
  localparam int MAX_EVENTS = 10;
  localparam int EV_CNT_W   = 4;

  // Mode keys and modes
  localparam logic [CODE_W-1:0] KEY_MODE_KEYBOARD = 5'd13;
  localparam logic [CODE_W-1:0] KEY_MODE_JOYSTICK = 5'd14;
  localparam logic [CODE_W-1:0] KEY_MODE_MOUSE    = 5'd15;
  localparam logic [CODE_W-1:0] KEY_NONE          = 5'd0;

  localparam logic [MODE_W-1:0] MODE_KEYBOARD = 2'd0;
  localparam logic [MODE_W-1:0] MODE_JOYSTICK = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MOUSE    = 2'd2;
  localparam logic [MODE_W-1:0] MODE_BAD      = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE     = 2'd0,
    ST_PRESSED  = 2'd1,
    ST_HELD     = 2'd2,
    ST_RELEASED = 2'd3
  } slot_state_t;

  typedef enum logic [1:0] {
    EV_PRESS    = 2'd0,
    EV_RELEASE  = 2'd1,
    EV_RESELECT = 2'd2,
    EV_SWITCH   = 2'd3
  } event_kind_t;

  // One tracked key, as held in the slot memory
  typedef struct packed {
    logic [CODE_W-1:0] code;
    slot_state_t       state;
    logic [TIME_W-1:0] press_time;
  } slot_rec_t;

  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } cell_pos_t;

  // Key code of each matrix cell, zero where no key sits
  localparam logic [CODE_W-1:0] CELL_CODE [8][8] = '{
    '{5'd0,  5'd9,  5'd5, 5'd1, 5'd17, 5'd16, 5'd0,  5'd0},
    '{5'd13, 5'd10, 5'd6, 5'd2, 5'd20, 5'd19, 5'd18, 5'd0},
    '{5'd14, 5'd11, 5'd7, 5'd3, 5'd23, 5'd22, 5'd21, 5'd0},
    '{5'd15, 5'd12, 5'd8, 5'd4, 5'd25, 5'd24, 5'd0,  5'd0},
    '{5'd0,  5'd0,  5'd0, 5'd0, 5'd0,  5'd0,  5'd0,  5'd0},
    '{5'd0,  5'd0,  5'd0, 5'd0, 5'd0,  5'd0,  5'd0,  5'd0},
    '{5'd0,  5'd0,  5'd0, 5'd0, 5'd0,  5'd0,  5'd0,  5'd0},
    '{5'd0,  5'd0,  5'd0, 5'd0, 5'd0,  5'd0,  5'd0,  5'd0}
  };

  function automatic logic [CODE_W-1:0] cell_code(input logic [POS_W-1:0] row,
                                                  input logic [POS_W-1:0] col);
    return CELL_CODE[row][col];
  endfunction

  // Inverse of the layout: where a key code sits
  function automatic cell_pos_t code_pos(input logic [CODE_W-1:0] code);
    cell_pos_t p;
    case (code)
      5'd1:    p = '{3'd0, 3'd3};
      5'd2:    p = '{3'd1, 3'd3};
      5'd3:    p = '{3'd2, 3'd3};
      5'd4:    p = '{3'd3, 3'd3};
      5'd5:    p = '{3'd0, 3'd2};
      5'd6:    p = '{3'd1, 3'd2};
      5'd7:    p = '{3'd2, 3'd2};
      5'd8:    p = '{3'd3, 3'd2};
      5'd9:    p = '{3'd0, 3'd1};
      5'd10:   p = '{3'd1, 3'd1};
      5'd11:   p = '{3'd2, 3'd1};
      5'd12:   p = '{3'd3, 3'd1};
      5'd13:   p = '{3'd1, 3'd0};
      5'd14:   p = '{3'd2, 3'd0};
      5'd15:   p = '{3'd3, 3'd0};
      5'd16:   p = '{3'd0, 3'd5};
      5'd17:   p = '{3'd0, 3'd4};
      5'd18:   p = '{3'd1, 3'd6};
      5'd19:   p = '{3'd1, 3'd5};
      5'd20:   p = '{3'd1, 3'd4};
      5'd21:   p = '{3'd2, 3'd6};
      5'd22:   p = '{3'd2, 3'd5};
      5'd23:   p = '{3'd2, 3'd4};
      5'd24:   p = '{3'd3, 3'd5};
      5'd25:   p = '{3'd3, 3'd4};
      default: p = '{3'd0, 3'd0};
    endcase
    return p;
  endfunction

  function automatic logic is_mode_key(input logic [CODE_W-1:0] code);
    return (code == KEY_MODE_KEYBOARD) || (code == KEY_MODE_JOYSTICK) ||
           (code == KEY_MODE_MOUSE);
  endfunction

endpackage

[rtl/core/kmt_if.sv]
// Channel interfaces of the key matrix tracker: scan input, event output
// and configuration writes. Depends on kmt_pkg for field widths.
interface kmt_in_if;
  logic                          valid;
  logic                          ready;
  logic [kmt_pkg::TIME_W-1:0]    time_ms;
  logic [kmt_pkg::MATRIX_W-1:0]  key_matrix;

  modport source (output valid, time_ms, key_matrix, input ready);
  modport sink   (input valid, time_ms, key_matrix, output ready);
endinterface

interface kmt_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  event_kind;
  logic [kmt_pkg::CODE_W-1:0]  ev_code;
  logic                        is_held;
  logic [kmt_pkg::MODE_W-1:0]  old_mode;
  logic [kmt_pkg::MODE_W-1:0]  new_mode;
  logic                        last_event;

  modport source (output valid, event_kind, ev_code, is_held, old_mode, new_mode,
                  last_event, input ready);
  modport sink   (input valid, event_kind, ev_code, is_held, old_mode, new_mode,
                  last_event, output ready);
endinterface

interface kmt_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [kmt_pkg::CFG_IDX_W-1:0]   reg_index;
  logic [kmt_pkg::CFG_DATA_W-1:0]  wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

[rtl/core/kmt_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module kmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/key_matrix_tracker_with_modes_top.sv]
// Key matrix tracker top level: debounce gate, slot update sweep, matrix walk
// and event emission. Depends on kmt_pkg, kmt_if.sv and kmt_ram.
//
//   channel  dir  handshake          payload
//   in_ch    in   valid / ready      time_ms[31:0], key_matrix[27:0]
//   out_ch   out  valid / ready      event_kind, ev_code, is_held, old_mode,
//                                    new_mode, last_event
//   cfg_ch   in   valid / ready (=1) reg_index[1:0], wdata[15:0]
//
// One scan at a time. A scan inside the debounce window is accepted and dropped.
// A processed scan reads, modifies and writes back each slot in turn through
// the single slot RAM, walks the matrix one cell per cycle, then emits each
// event by RAM read, format and output register, waiting out any output stall.
// Reset is synchronous; slot memory contents need no clearing as each slot
// carries a used bit in flops. out_ch stalls freeze the sequencer.
module key_matrix_tracker_with_modes_top #(
  parameter int LIST_SLOTS = 10,
  parameter int ROWS       = 4,
  parameter int COLS       = 7
) (
  input  logic      clk,
  input  logic      rst_n,
  kmt_in_if.sink    in_ch,
  kmt_out_if.source out_ch,
  kmt_cfg_if.sink   cfg_ch
);
  import kmt_pkg::*;

  localparam int SLOT_W = (LIST_SLOTS > 1) ? $clog2(LIST_SLOTS) : 1;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_W  = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int REC_W  = $bits(slot_rec_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_A_RD,
    S_A_WB,
    S_B,
    S_DECIDE,
    S_C_RD,
    S_C_EV,
    S_C_OUT
  } fsm_t;

  fsm_t                   state_r;
  logic [DELAY_W-1:0]     debounce_r;
  logic [DELAY_W-1:0]     hold_r;
  logic [TIME_W-1:0]      last_scan_r;
  logic [TIME_W-1:0]      now_r;
  logic [MATRIX_W-1:0]    matrix_r;
  logic [LIST_SLOTS-1:0]  used_r;
  logic [LIST_SLOTS-1:0]  changed_r;
  logic [LIST_SLOTS-1:0]  ev_r;
  logic [LIST_SLOTS-1:0]  pend_r;
  logic [(1<<CODE_W)-1:0] claimed_r;
  logic [SLOT_W-1:0]      slot_r;
  logic [ROW_W-1:0]       row_r;
  logic [COL_W-1:0]       col_r;
  logic [CELL_BIT_W-1:0]  bit_r;
  logic [SLOT_W-1:0]      cidx_r;
  logic [EV_CNT_W-1:0]    ev_cnt_r;
  logic [MODE_W-1:0]      mode_r;
  logic                   out_valid_r;
  event_kind_t            out_kind_r;
  logic [CODE_W-1:0]      out_code_r;
  logic                   out_held_r;
  logic [MODE_W-1:0]      out_old_r;
  logic [MODE_W-1:0]      out_new_r;
  logic                   out_last_r;

  logic                   in_acc;
  logic                   scan_skip;
  logic [TIME_W-1:0]      since_scan;

  // Slot RAM ports
  logic                   ram_we;
  logic [SLOT_W-1:0]      ram_waddr;
  slot_rec_t              ram_wrec;
  logic                   ram_re;
  logic [SLOT_W-1:0]      ram_raddr;
  logic [REC_W-1:0]       ram_rdata;
  slot_rec_t              rec;

  // Slot sweep
  cell_pos_t              a_pos;
  logic [CELL_BIT_W-1:0]  a_bit;
  logic                   a_active;
  logic [TIME_W-1:0]      a_elapsed;
  logic                   a_hold;
  logic                   a_free;
  logic                   a_ch;
  slot_state_t            a_state;
  logic                   a_ev;

  // Matrix walk
  logic [CODE_W-1:0]      b_code;
  logic                   b_active;
  logic                   b_take;
  logic                   free_found;
  logic [SLOT_W-1:0]      free_idx;
  logic                   b_last_cell;

  // Event emission
  logic [SLOT_W-1:0]      pick_idx;
  logic [LIST_SLOTS-1:0]  pend_rest;
  logic                   ev_last;
  event_kind_t            e_kind;
  logic                   e_held;
  logic [MODE_W-1:0]      e_new;
  logic [MODE_W-1:0]      e_target;

  assign in_acc       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  // Debounce gate
  assign since_scan = in_ch.time_ms - last_scan_r;
  assign scan_skip  = (since_scan <= TIME_W'(debounce_r));

  assign rec = ram_rdata;

  // Slot sweep: free idle slots, advance the others
  always_comb begin
    a_pos     = code_pos(rec.code);
    a_bit     = (CELL_BIT_W'(a_pos.row) * CELL_BIT_W'(COLS)) + CELL_BIT_W'(a_pos.col);
    a_active  = (a_bit < CELL_BIT_W'(MATRIX_W)) && matrix_r[a_bit[4:0]];
    a_elapsed = now_r - rec.press_time;
    a_hold    = (a_elapsed > TIME_W'(hold_r));
    a_free    = 1'b0;
    a_ch      = 1'b0;
    a_state   = rec.state;
    case (rec.state)
      ST_IDLE: begin
        a_free = 1'b1;
      end
      ST_PRESSED: begin
        if (a_hold) begin
          a_state = ST_HELD;
          a_ch    = 1'b1;
        end else if (!a_active) begin
          a_state = ST_RELEASED;
          a_ch    = 1'b1;
        end
      end
      ST_HELD: begin
        if (!a_active) begin
          a_state = ST_RELEASED;
          a_ch    = 1'b1;
        end
      end
      default: begin
        a_state = ST_IDLE;
        a_ch    = 1'b1;
      end
    endcase
    a_ev = (a_state == ST_RELEASED) ||
           (((a_state == ST_PRESSED) || (a_state == ST_HELD)) && !is_mode_key(rec.code));
  end

  // First free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = LIST_SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_W'(i);
      end
    end
  end

  // Matrix walk: new keys take a slot
  assign b_code      = cell_code(POS_W'(row_r), POS_W'(col_r));
  assign b_active    = (bit_r < CELL_BIT_W'(MATRIX_W)) && matrix_r[bit_r[4:0]];
  assign b_take      = (b_code != KEY_NONE) && b_active && !claimed_r[b_code] && free_found;
  assign b_last_cell = (row_r == ROW_W'(ROWS - 1)) && (col_r == COL_W'(COLS - 1));

  // Lowest pending event slot
  always_comb begin
    pick_idx = '0;
    for (int i = LIST_SLOTS - 1; i >= 0; i--) begin
      if (pend_r[i]) begin
        pick_idx = SLOT_W'(i);
      end
    end
  end

  always_comb begin
    pend_rest = pend_r;
    pend_rest[cidx_r] = 1'b0;
  end

  assign ev_last = (pend_rest == '0) || (ev_cnt_r == EV_CNT_W'(MAX_EVENTS - 1));

  // Event formatting from the slot read back
  always_comb begin
    e_target = MODE_W'(rec.code - KEY_MODE_KEYBOARD);
    e_held   = 1'b0;
    e_new    = mode_r;
    e_kind   = EV_PRESS;
    case (rec.state)
      ST_RELEASED: begin
        if (is_mode_key(rec.code)) begin
          if (e_target == mode_r) begin
            e_kind = EV_RESELECT;
          end else begin
            e_kind = EV_SWITCH;
            e_new  = e_target;
          end
        end else begin
          e_kind = EV_RELEASE;
        end
      end
      ST_HELD: begin
        e_held = 1'b1;
      end
      default: begin
        e_held = 1'b0;
      end
    endcase
  end

  // Slot RAM access
  always_comb begin
    ram_re    = (state_r == S_A_RD) || (state_r == S_C_RD);
    ram_raddr = (state_r == S_C_RD) ? pick_idx : slot_r;
    if (state_r == S_B) begin
      ram_we    = b_take;
      ram_waddr = free_idx;
      ram_wrec  = '{code: b_code, state: ST_PRESSED, press_time: now_r};
    end else begin
      ram_we    = (state_r == S_A_WB) && used_r[slot_r] && !a_free;
      ram_waddr = slot_r;
      ram_wrec  = '{code: rec.code, state: a_state, press_time: rec.press_time};
    end
  end

  kmt_ram #(
    .WIDTH (REC_W),
    .DEPTH (LIST_SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wrec),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Sequencer, state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      debounce_r  <= DEBOUNCE_RST;
      hold_r      <= HOLD_RST;
      last_scan_r <= '0;
      used_r      <= '0;
      changed_r   <= '0;
      ev_r        <= '0;
      pend_r      <= '0;
      claimed_r   <= '0;
      slot_r      <= '0;
      row_r       <= '0;
      col_r       <= '0;
      bit_r       <= '0;
      cidx_r      <= '0;
      ev_cnt_r    <= '0;
      mode_r      <= MODE_KEYBOARD;
      out_valid_r <= 1'b0;
    end else begin
      // configuration transaction
      if (cfg_ch.valid) begin
        case (cfg_ch.reg_index)
          REG_DEBOUNCE: debounce_r <= cfg_ch.wdata;
          REG_HOLD:     hold_r     <= cfg_ch.wdata;
          default:      ;
        endcase
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            now_r    <= in_ch.time_ms;
            matrix_r <= in_ch.key_matrix;
            if (!scan_skip) begin
              last_scan_r <= in_ch.time_ms;
              claimed_r   <= '0;
              slot_r      <= '0;
              state_r     <= S_A_RD;
            end
          end
        end
        S_A_RD: begin
          state_r <= S_A_WB;
        end
        S_A_WB: begin
          if (used_r[slot_r]) begin
            if (a_free) begin
              used_r[slot_r]    <= 1'b0;
              changed_r[slot_r] <= 1'b0;
              ev_r[slot_r]      <= 1'b0;
            end else begin
              changed_r[slot_r]   <= a_ch;
              ev_r[slot_r]        <= a_ev;
              claimed_r[rec.code] <= 1'b1;
            end
          end
          if (slot_r == SLOT_W'(LIST_SLOTS - 1)) begin
            row_r   <= '0;
            col_r   <= '0;
            bit_r   <= '0;
            state_r <= S_B;
          end else begin
            slot_r  <= slot_r + 1'b1;
            state_r <= S_A_RD;
          end
        end
        S_B: begin
          if (b_take) begin
            used_r[free_idx]    <= 1'b1;
            changed_r[free_idx] <= 1'b1;
            ev_r[free_idx]      <= !is_mode_key(b_code);
          end
          bit_r <= bit_r + 1'b1;
          if (col_r == COL_W'(COLS - 1)) begin
            col_r <= '0;
            row_r <= row_r + 1'b1;
          end else begin
            col_r <= col_r + 1'b1;
          end
          if (b_last_cell) begin
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          ev_cnt_r <= '0;
          if ((|changed_r) && (|ev_r)) begin
            pend_r  <= ev_r;
            state_r <= S_C_RD;
          end else begin
            state_r <= S_IDLE;
          end
        end
        S_C_RD: begin
          cidx_r  <= pick_idx;
          state_r <= S_C_EV;
        end
        S_C_EV: begin
          out_valid_r    <= 1'b1;
          out_kind_r     <= e_kind;
          out_code_r     <= rec.code;
          out_held_r     <= e_held;
          out_old_r      <= mode_r;
          out_new_r      <= e_new;
          out_last_r     <= ev_last;
          mode_r         <= e_new;
          pend_r[cidx_r] <= 1'b0;
          ev_cnt_r       <= ev_cnt_r + 1'b1;
          state_r        <= S_C_OUT;
        end
        S_C_OUT: begin
          if (out_ch.ready) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              pend_r  <= '0;
              state_r <= S_IDLE;
            end else begin
              state_r <= S_C_RD;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.event_kind = out_kind_r;
  assign out_ch.ev_code    = out_code_r;
  assign out_ch.is_held    = out_held_r;
  assign out_ch.old_mode   = out_old_r;
  assign out_ch.new_mode   = out_new_r;
  assign out_ch.last_event = out_last_r;

  // Checks
  a_ev_in_used: assert property (@(posedge clk) disable iff (!rst_n)
    (ev_r & ~used_r) == '0)
    else $error("event flag on a free slot");

  a_chg_in_used: assert property (@(posedge clk) disable iff (!rst_n)
    (changed_r & ~used_r) == '0)
    else $error("change flag on a free slot");

  a_pend_in_ev: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r & ~ev_r) == '0)
    else $error("pending event on a slot without event");

  a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r != MODE_BAD)
    else $error("mode register out of range");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("input taken while an event is outstanding");

  a_ev_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (ev_cnt_r == EV_CNT_W'(MAX_EVENTS)) |-> out_ch.last_event)
    else $error("event count beyond cap without last flag");

endmodule
